[src/mlfr_pkg.sv]
// ----------------------------------------------------------------------------
// mlfr_pkg
// Shared types and constants for the magic/length frame receiver.
// ----------------------------------------------------------------------------
package mlfr_pkg;

  localparam int BUFFER_DEPTH_DEF = 262144;

  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 18;
  localparam int LEN_W   = 19;
  localparam int SEQ_W   = 32;
  localparam int EVENT_W = 2;

  localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 19'd184320;

  // Magic "TDKVIMG1", first byte in the low lane
  localparam logic [63:0] MAGIC_SEQ = 64'h31474D49564B4454;
  localparam int          MAGIC_LEN = 8;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2
  } phase_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_HDR  = 2'd0,
    EV_BYTE = 2'd1,
    EV_DONE = 2'd2,
    EV_REJ  = 2'd3
  } event_t;

  typedef struct packed {
    event_t             event_res;
    logic [ADDR_W-1:0]  store_addr;
    logic [BYTE_W-1:0]  store_byte;
    logic [LEN_W-1:0]   frame_length;
    logic [SEQ_W-1:0]   frame_seq;
  } result_t;

endpackage

[src/mlfr_in_stage.sv]
// ----------------------------------------------------------------------------
// mlfr_in_stage
// Input register: holds one received byte until the deframer steps on it.
// ----------------------------------------------------------------------------
module mlfr_in_stage import mlfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  logic              adv,
  output logic              s1_valid,
  output logic [BYTE_W-1:0] s1_byte
);

  logic              valid_r;
  logic [BYTE_W-1:0] byte_r;

  assign in_ready = !valid_r || adv;
  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

[src/mlfr_deframer.sv]
// ----------------------------------------------------------------------------
// mlfr_deframer
// Frame state: magic hunt, length collection, payload addressing and
// frame completion bookkeeping. One byte per step.
// ----------------------------------------------------------------------------
module mlfr_deframer import mlfr_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_wr_data,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  output result_t           res
);

  localparam int CAP_INT = (BUFFER_DEPTH > (2**LEN_W - 1)) ? (2**LEN_W - 1) : BUFFER_DEPTH;
  localparam logic [LEN_W-1:0] DEPTH_CAP = LEN_W'(CAP_INT);

  phase_t            phase_r,    phase_nxt;
  logic [2:0]        mpos_r,     mpos_nxt;
  logic [1:0]        lpos_r,     lpos_nxt;
  logic [23:0]       ann_r,      ann_nxt;
  logic [LEN_W-1:0]  pay_len_r,  pay_len_nxt;
  logic [LEN_W-1:0]  cnt_r,      cnt_nxt;
  logic [LEN_W-1:0]  last_len_r, last_len_nxt;
  logic [SEQ_W-1:0]  seq_r,      seq_nxt;
  logic [LEN_W-1:0]  max_r;

  logic [LEN_W-1:0]  limit;
  logic [31:0]       ann_full;
  logic [LEN_W:0]    cnt_inc;

  assign limit    = (max_r > DEPTH_CAP) ? DEPTH_CAP : max_r;
  assign ann_full = {rx_byte, ann_r};
  assign cnt_inc  = {1'b0, cnt_r} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_FRAME_RESET;
    end else if (cfg_wr_en) begin
      max_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      mpos_r     <= '0;
      lpos_r     <= '0;
      ann_r      <= '0;
      pay_len_r  <= '0;
      cnt_r      <= '0;
      last_len_r <= '0;
      seq_r      <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      mpos_r     <= mpos_nxt;
      lpos_r     <= lpos_nxt;
      ann_r      <= ann_nxt;
      pay_len_r  <= pay_len_nxt;
      cnt_r      <= cnt_nxt;
      last_len_r <= last_len_nxt;
      seq_r      <= seq_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    mpos_nxt       = mpos_r;
    lpos_nxt       = lpos_r;
    ann_nxt        = ann_r;
    pay_len_nxt    = pay_len_r;
    cnt_nxt        = cnt_r;
    last_len_nxt   = last_len_r;
    seq_nxt        = seq_r;
    res.event_res  = EV_HDR;
    res.store_addr = '0;
    res.store_byte = '0;

    case (phase_r)
      PH_LEN: begin
        lpos_nxt = lpos_r + 2'd1;
        case (lpos_r)
          2'd0:    ann_nxt[7:0]   = rx_byte;
          2'd1:    ann_nxt[15:8]  = rx_byte;
          2'd2:    ann_nxt[23:16] = rx_byte;
          default: begin
            if (ann_full == 32'd0 || ann_full > {13'd0, limit}) begin
              phase_nxt     = PH_HUNT;
              mpos_nxt      = '0;
              lpos_nxt      = '0;
              ann_nxt       = '0;
              cnt_nxt       = '0;
              res.event_res = EV_REJ;
            end else begin
              phase_nxt    = PH_PAY;
              pay_len_nxt  = ann_full[LEN_W-1:0];
              last_len_nxt = '0;
              cnt_nxt      = '0;
            end
          end
        endcase
      end
      PH_PAY: begin
        res.store_addr = cnt_r[ADDR_W-1:0];
        res.store_byte = rx_byte;
        if (cnt_inc >= {1'b0, pay_len_r}) begin
          last_len_nxt  = pay_len_r;
          seq_nxt       = seq_r + 1'b1;
          phase_nxt     = PH_HUNT;
          mpos_nxt      = '0;
          lpos_nxt      = '0;
          ann_nxt       = '0;
          cnt_nxt       = '0;
          res.event_res = EV_DONE;
        end else begin
          cnt_nxt       = cnt_inc[LEN_W-1:0];
          res.event_res = EV_BYTE;
        end
      end
      default: begin
        if (rx_byte == MAGIC_SEQ[mpos_r*8 +: 8]) begin
          mpos_nxt = mpos_r + 3'd1;
          if (mpos_r == 3'(MAGIC_LEN - 1)) begin
            phase_nxt = PH_LEN;
            lpos_nxt  = '0;
            ann_nxt   = '0;
          end
        end else begin
          phase_nxt = PH_HUNT;
          mpos_nxt  = (rx_byte == MAGIC_SEQ[7:0]) ? 3'd1 : 3'd0;
        end
      end
    endcase

    res.frame_length = last_len_nxt;
    res.frame_seq    = seq_nxt;
  end

endmodule

[src/mlfr_out_stage.sv]
// ----------------------------------------------------------------------------
// mlfr_out_stage
// Result register toward the downstream receiver.
// ----------------------------------------------------------------------------
module mlfr_out_stage import mlfr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    s1_valid,
  input  result_t res,
  output logic    adv,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r;
  result_t res_r;

  assign adv       = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      res_r <= res;
    end
  end

endmodule

[src/magic_length_frame_receiver.sv]
// ----------------------------------------------------------------------------
// magic_length_frame_receiver
// Deframer for a serial byte stream: magic hunt, 4-byte little-endian
// length, then payload bytes with their buffer offsets.
//
// Input channel in_*: one received byte per transfer (valid/ready).
// Output channel out_*: exactly one result per input byte, in order:
//   event code, store address/byte for payload, last frame length and
//   completed frame count as they stand after that byte.
// Config: cfg_wr_en/cfg_wr_data write max_frame_bytes; write only when idle.
// Path: an accepted byte is held in the input register, then its result is
//   taken into the output (result) register.
// Throughput: one byte per cycle while out_ready is high; the frame state
//   update is a single compare/increment step between the two registers.
// Stall: with out_ready low the result holds, the input register still
//   takes one more byte if it is empty, then in_ready drops.
// Reset (rst_n low, synchronous): both channels empty, back to hunting,
//   counters and last length cleared, max_frame_bytes = 184320.
// ----------------------------------------------------------------------------
module magic_length_frame_receiver import mlfr_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [LEN_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BYTE_W-1:0]  in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [EVENT_W-1:0] out_event_res,
  output logic [ADDR_W-1:0]  out_store_addr,
  output logic [BYTE_W-1:0]  out_store_byte,
  output logic [LEN_W-1:0]   out_frame_length,
  output logic [SEQ_W-1:0]   out_frame_seq
);

  logic              adv;
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  result_t           res;
  result_t           out_res;

  mlfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .adv        (adv),
    .s1_valid   (s1_valid),
    .s1_byte    (s1_byte)
  );

  mlfr_deframer #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_deframer (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (s1_valid && adv),
    .rx_byte     (s1_byte),
    .res         (res)
  );

  mlfr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .res       (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_event_res    = out_res.event_res;
  assign out_store_addr   = out_res.store_addr;
  assign out_store_byte   = out_res.store_byte;
  assign out_frame_length = out_res.frame_length;
  assign out_frame_seq    = out_res.frame_seq;

endmodule

[src/mlfr_checker.sv]
// ----------------------------------------------------------------------------
// mlfr_port_checks
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module mlfr_port_checks import mlfr_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               cfg_wr_en,
  input logic [LEN_W-1:0]   cfg_wr_data,
  input logic               in_valid,
  input logic               in_ready,
  input logic [BYTE_W-1:0]  in_rx_byte,
  input logic               out_valid,
  input logic               out_ready,
  input logic [EVENT_W-1:0] out_event_res,
  input logic [ADDR_W-1:0]  out_store_addr,
  input logic [BYTE_W-1:0]  out_store_byte,
  input logic [LEN_W-1:0]   out_frame_length,
  input logic [SEQ_W-1:0]   out_frame_seq
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res)
      && $stable(out_store_addr) && $stable(out_frame_seq))
    else $error("stalled output transfer changed");

  a_hdr_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_HDR || out_event_res == EV_REJ)
      |-> out_store_addr == '0 && out_store_byte == '0)
    else $error("store fields set on a non-payload event");

  a_byte_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_BYTE |-> out_frame_length == '0)
    else $error("frame length not cleared during payload");

  a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_DONE
      |-> out_frame_length[ADDR_W-1:0] == out_store_addr + 1'b1)
    else $error("completed length does not match last address");

endmodule

bind magic_length_frame_receiver mlfr_port_checks u_mlfr_port_checks (.*);
